// ===== rtl/dsdc_pkg.sv =====
package dsdc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_INDEX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_REGION    = 3'd5;

	localparam logic [2:0]  DMA_TICKS   = 3'd4;
	localparam logic [15:0] READ_BASE   = 16'h8000;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] fetched_byte;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  dac_level;
		logic        cpu_stall;
		logic        dma_request;
		logic [15:0] dma_address;
		logic        irq_pending;
		logic        channel_active;
	} out_item_t;

	typedef struct packed {
		logic [3:0] rate_index;
		logic       loop_enable;
		logic       irq_enable;
		logic [7:0] start_address_code;
		logic [7:0] length_code;
		logic       pal_region;
	} cfg_t;

	function automatic logic [8:0] rate_value(input logic pal, input logic [3:0] idx);
		logic [8:0] r;
		r = 9'd428;
		if (pal) begin
			case (idx)
				4'd0:  r = 9'd398;
				4'd1:  r = 9'd354;
				4'd2:  r = 9'd316;
				4'd3:  r = 9'd298;
				4'd4:  r = 9'd276;
				4'd5:  r = 9'd236;
				4'd6:  r = 9'd210;
				4'd7:  r = 9'd198;
				4'd8:  r = 9'd176;
				4'd9:  r = 9'd148;
				4'd10: r = 9'd132;
				4'd11: r = 9'd118;
				4'd12: r = 9'd98;
				4'd13: r = 9'd78;
				4'd14: r = 9'd66;
				default: r = 9'd50;
			endcase
		end else begin
			case (idx)
				4'd0:  r = 9'd428;
				4'd1:  r = 9'd380;
				4'd2:  r = 9'd340;
				4'd3:  r = 9'd320;
				4'd4:  r = 9'd286;
				4'd5:  r = 9'd254;
				4'd6:  r = 9'd226;
				4'd7:  r = 9'd214;
				4'd8:  r = 9'd190;
				4'd9:  r = 9'd160;
				4'd10: r = 9'd142;
				4'd11: r = 9'd128;
				4'd12: r = 9'd106;
				4'd13: r = 9'd84;
				4'd14: r = 9'd72;
				default: r = 9'd54;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/dsdc_cfg_regs.sv =====
module dsdc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dsdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dsdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dsdc_pkg::cfg_t                   cfg
);
	import dsdc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATE_INDEX:    cfg_q.rate_index         <= cfg_data[3:0];
				REG_LOOP_ENABLE:   cfg_q.loop_enable        <= cfg_data[0];
				REG_IRQ_ENABLE:    cfg_q.irq_enable         <= cfg_data[0];
				REG_START_ADDRESS: cfg_q.start_address_code <= cfg_data;
				REG_LENGTH:        cfg_q.length_code        <= cfg_data;
				REG_PAL_REGION:    cfg_q.pal_region         <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/dsdc_core.sv =====
module dsdc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  dsdc_pkg::in_item_t   in_item,
	input  dsdc_pkg::cfg_t       cfg,
	output dsdc_pkg::out_item_t  result
);
	import dsdc_pkg::*;

	typedef struct packed {
		logic [11:0] bytes_remaining;
		logic [14:0] fetch_address;
		logic [2:0]  dma_delay;
		logic [8:0]  period_count;
		logic [2:0]  bit_index;
		logic        buffer_full;
		logic [7:0]  buffer_byte;
		logic        shifter_valid;
		logic [7:0]  shifter_byte;
		logic [6:0]  dac_value;
		logic        irq_flag;
		logic        stall_line;
	} state_t;

	localparam state_t STATE_RESET = '{period_count: rate_value(1'b0, 4'd0), default: '0};

	state_t      state_q;
	state_t      nx;
	logic [7:0]  moved;
	logic [8:0]  reload;
	logic [14:0] start_addr;
	logic [11:0] start_len;

	assign reload     = rate_value(cfg.pal_region, cfg.rate_index);
	assign start_addr = {1'b1, cfg.start_address_code, 6'b0};
	assign start_len  = {cfg.length_code, 4'b0001};

	always_comb begin
		nx    = state_q;
		moved = '0;
		case (in_item.op)
			OP_TICK: begin
				// DMA sequence: the byte lands on the last tick
				if (nx.dma_delay != 3'd0) begin
					nx.dma_delay = nx.dma_delay - 3'd1;
					if (nx.dma_delay == 3'd0) begin
						nx.stall_line      = 1'b0;
						nx.buffer_byte     = in_item.fetched_byte;
						nx.buffer_full     = 1'b1;
						nx.bytes_remaining = nx.bytes_remaining - 12'd1;
						nx.fetch_address   = nx.fetch_address + 15'd1;
						if (nx.bytes_remaining == 12'd0) begin
							if (cfg.loop_enable) begin
								nx.fetch_address   = start_addr;
								nx.bytes_remaining = start_len;
							end else if (cfg.irq_enable) begin
								nx.irq_flag = 1'b1;
							end
						end
					end
				end
				nx.period_count = nx.period_count - 9'd1;
				if (nx.period_count == 9'd0) begin
					if (nx.shifter_valid) begin
						moved = nx.shifter_byte[nx.bit_index] ? {1'b0, nx.dac_value} + 8'd2
						                                      : {1'b0, nx.dac_value} - 8'd2;
						// drop a move that leaves 0..127
						if (!moved[7])
							nx.dac_value = moved[6:0];
					end
					nx.bit_index = nx.bit_index + 3'd1;
					if (nx.bit_index == 3'd0) begin
						nx.shifter_valid = nx.buffer_full;
						if (nx.buffer_full) begin
							nx.shifter_byte = nx.buffer_byte;
							nx.buffer_full  = 1'b0;
						end
					end
					nx.period_count = reload;
				end
				if (nx.bytes_remaining != 12'd0 && !nx.buffer_full && nx.dma_delay == 3'd0) begin
					nx.stall_line = 1'b1;
					nx.dma_delay  = DMA_TICKS;
				end
			end
			OP_START: begin
				if (nx.bytes_remaining == 12'd0) begin
					nx.fetch_address   = start_addr;
					nx.bytes_remaining = start_len;
				end
			end
			OP_STOP: begin
				nx.bytes_remaining = '0;
				nx.dma_delay       = '0;
				nx.stall_line      = 1'b0;
			end
			default: ;
		endcase
	end

	always_comb begin
		result.dac_level      = state_q.dac_value;
		result.cpu_stall      = nx.stall_line;
		result.dma_request    = (nx.dma_delay == 3'd1);
		result.dma_address    = (nx.dma_delay == 3'd1) ? (READ_BASE | {1'b0, nx.fetch_address})
		                                               : READ_BASE;
		result.irq_pending    = nx.irq_flag;
		result.channel_active = (nx.bytes_remaining != 12'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= nx;
		end
	end

endmodule

// ===== rtl/dsdc_out_buf.sv =====
module dsdc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dsdc_pkg::out_item_t  push_item,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dsdc_pkg::out_item_t  out_data
);
	import dsdc_pkg::*;

	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (out_valid_q)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_item;
		end else if (push) begin
			if (out_valid_q)
				skid_q <= push_item;
			else
				out_q <= push_item;
		end
	end

endmodule

// ===== rtl/delta_sample_dma_channel.sv =====
// Delta-modulation sample channel with a byte-fetch DMA sequencer.
// Input channel (in_valid / in_stall / in_data): one transfer per CPU tick,
// carrying the op (tick, start, stop) and the memory byte returned for a
// DMA read. Output channel (out_valid / out_stall / out_data): exactly one
// result transfer per input transfer, in order: DAC level before the tick,
// CPU stall, DMA request and address, IRQ flag and channel activity.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): register
// writes, always ready; write only while no item is in flight.
// The result of an item is formed combinationally and registered in the
// output buffer. Throughput: one item per cycle while in_stall is low; the
// channel state updates combinationally between state and output registers.
// The output side has a two-entry buffer, so input is taken while a result
// waits; in_stall rises only when both entries hold results under stall.
// Reset clears the channel state, the configuration and the buffer valid
// flags; the period timer loads the first NTSC period.
module delta_sample_dma_channel (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  dsdc_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output dsdc_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dsdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dsdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dsdc_pkg::*;

	cfg_t      cfg;
	out_item_t result;
	logic      accept;
	logic      buf_full;

	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	dsdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dsdc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_data),
		.cfg     (cfg),
		.result  (result)
	);

	dsdc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
